// ----- hw/rtl/assert_macros.svh -----
// Assertion macros for RTL files that check their own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define MCC_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define MCC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- hw/rtl/mcc_pkg.sv -----
// Package of shared constants and types for the minimum coin change block.
`default_nettype none

package mcc_pkg;

	localparam int MAX_AMOUNT_DEF = 1023;
	localparam int NUM_COINS_DEF  = 4;
	localparam int NUM_COIN_REGS  = 4;

	localparam int AMT_W   = 10;
	localparam int COIN_W  = 10;
	localparam int CNT_W   = 11;
	localparam int IDX_W   = 8;
	localparam int KW      = $clog2(NUM_COIN_REGS);
	localparam int ENTRY_W = CNT_W + COIN_W;

	localparam logic [CNT_W-1:0] NO_WAY = 11'h7FF;

	localparam logic [IDX_W-1:0] REG_COIN_A = 8'd0;
	localparam logic [IDX_W-1:0] REG_COIN_B = 8'd1;
	localparam logic [IDX_W-1:0] REG_COIN_C = 8'd2;
	localparam logic [IDX_W-1:0] REG_COIN_D = 8'd3;

	localparam logic [COIN_W-1:0] COIN_A_RST = 10'd1;
	localparam logic [COIN_W-1:0] COIN_B_RST = 10'd3;
	localparam logic [COIN_W-1:0] COIN_C_RST = 10'd4;
	localparam logic [COIN_W-1:0] COIN_D_RST = 10'd0;

	// One issue per coin slot from the sequencer; the table is read only for a usable coin.
	typedef struct packed {
		logic vld;
		logic usable;
		logic first;
		logic last;
	} issue_t;

endpackage

`default_nettype wire

// ----- hw/rtl/mcc_ifs.sv -----
// Handshake interfaces for the amount, result and configuration channels.
`default_nettype none

interface mcc_amount_if;
	logic                      valid;
	logic                      ready;
	logic [mcc_pkg::AMT_W-1:0] amount;

	modport source (output valid, output amount, input ready);
	modport sink   (input valid, input amount, output ready);
endinterface

interface mcc_result_if;
	logic                       valid;
	logic                       ready;
	logic [mcc_pkg::AMT_W-1:0]  min_coins;
	logic                       reachable;
	logic [mcc_pkg::COIN_W-1:0] first_coin;

	modport source (output valid, output min_coins, output reachable, output first_coin,
		input ready);
	modport sink   (input valid, input min_coins, input reachable, input first_coin,
		output ready);
endinterface

interface mcc_cfg_if;
	logic                       valid;
	logic                       ready;
	logic [mcc_pkg::IDX_W-1:0]  index;
	logic [mcc_pkg::COIN_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/min_coin_change_top.sv -----
// Top level of the minimum coin change block: table RAM, sequencer, update stage, result register.
//
//  channel | dir | fields                               | accepted when
//  --------+-----+--------------------------------------+----------------------------
//  req     | in  | amount                               | req.valid && req.ready
//  rsp     | out | min_coins, reachable, first_coin     | rsp.valid && rsp.ready
//  cfg     | in  | index, data (coin_a..coin_d at 0..3) | cfg.valid && cfg.ready
//
// Per item, the fill walks all K active coin slots (NUM_COINS, at most four) for each
// sum up to the amount: the single read port of the table RAM serves one coin slot
// per cycle, and the write of each sum overlaps the first read of the next through a
// one-entry bypass. Amount zero skips the fill, an amount above MAX_AMOUNT all table
// steps. Reset clears control only; the table needs no clearing pass, since every
// entry is written before it is read. A stalled result holds in the output register,
// and the block waits in its response step until it is taken.
`default_nettype none

module min_coin_change_top #(
	parameter int MAX_AMOUNT = mcc_pkg::MAX_AMOUNT_DEF,
	parameter int NUM_COINS  = mcc_pkg::NUM_COINS_DEF
) (
	input wire logic   clk,
	input wire logic   arst_n,
	mcc_amount_if.sink req,
	mcc_result_if.source rsp,
	mcc_cfg_if.sink    cfg
);

	localparam int AW = $clog2(MAX_AMOUNT + 1);

	// coin registers
	logic [mcc_pkg::COIN_W-1:0] coins [mcc_pkg::NUM_COIN_REGS];

	// sequencer to update stage
	mcc_pkg::issue_t            iss;
	logic [AW-1:0]              iss_sum;
	logic [mcc_pkg::COIN_W-1:0] iss_coin;
	logic                       init_we;

	// table RAM ports
	logic                       ram_we;
	logic [AW-1:0]              ram_waddr;
	logic [mcc_pkg::ENTRY_W-1:0] ram_wdata;
	logic                       ram_re;
	logic [AW-1:0]              ram_raddr;
	logic [mcc_pkg::ENTRY_W-1:0] ram_rdata;

	// result register
	logic                       rsp_free;
	logic                       rsp_load;
	logic                       rsp_over;
	logic                       rsp_vld_q;
	logic [mcc_pkg::AMT_W-1:0]  min_q;
	logic                       reach_q;
	logic [mcc_pkg::COIN_W-1:0] first_q;
	logic [mcc_pkg::CNT_W-1:0]  fin_cnt;
	logic                       fin_reach;

	// configuration is always taken
	assign cfg.ready = 1'b1;

	mcc_coin_regs u_coin_regs (
		.clk    (clk),
		.arst_n (arst_n),
		.we     (cfg.valid && cfg.ready),
		.index  (cfg.index),
		.data   (cfg.data),
		.coins  (coins)
	);

	mcc_seq #(
		.MAX_AMOUNT (MAX_AMOUNT),
		.NUM_COINS  (NUM_COINS)
	) u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req.valid),
		.req_amount (req.amount),
		.req_ready  (req.ready),
		.coins      (coins),
		.rsp_free   (rsp_free),
		.rsp_load   (rsp_load),
		.rsp_over   (rsp_over),
		.iss        (iss),
		.iss_sum    (iss_sum),
		.iss_coin   (iss_coin),
		.init_we    (init_we),
		.rd_en      (ram_re),
		.rd_addr    (ram_raddr)
	);

	mcc_update #(
		.MAX_AMOUNT (MAX_AMOUNT)
	) u_update (
		.clk      (clk),
		.arst_n   (arst_n),
		.iss      (iss),
		.iss_sum  (iss_sum),
		.iss_addr (ram_raddr),
		.iss_coin (iss_coin),
		.init_we  (init_we),
		.rd_data  (ram_rdata),
		.we       (ram_we),
		.waddr    (ram_waddr),
		.wdata    (ram_wdata)
	);

	// best count and first coin of every sum, packed {first, count}
	mcc_ram #(
		.W     (mcc_pkg::ENTRY_W),
		.DEPTH (MAX_AMOUNT + 1)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// final entry: zero every field unless the amount is in range and formable
	assign fin_cnt   = ram_rdata[mcc_pkg::CNT_W-1:0];
	assign fin_reach = !rsp_over && (fin_cnt != mcc_pkg::NO_WAY);
	assign rsp_free  = !rsp_vld_q || rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_vld_q <= 1'b0;
		end else if (rsp_load) begin
			rsp_vld_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rsp_load) begin
			reach_q <= fin_reach;
			min_q   <= fin_reach ? fin_cnt[mcc_pkg::AMT_W-1:0] : '0;
			first_q <= fin_reach ? ram_rdata[mcc_pkg::ENTRY_W-1:mcc_pkg::CNT_W] : '0;
		end
	end

	assign rsp.valid      = rsp_vld_q;
	assign rsp.min_coins  = min_q;
	assign rsp.reachable  = reach_q;
	assign rsp.first_coin = first_q;

`include "assert_macros.svh"

	// after an accept, the block is busy in the following cycle
	`MCC_ASSERT_NEXT(a_busy_after_accept, req.valid && req.ready, !req.ready,
		"accept while busy")
	// table writes stay inside the table
	`MCC_ASSERT_NOW(a_wr_in_range, ram_we, int'(ram_waddr) <= MAX_AMOUNT,
		"write out of range")
	// an unreachable result carries zero count and zero coin
	`MCC_ASSERT_NOW(a_unreach_zero, rsp.valid && !rsp.reachable,
		(rsp.min_coins == '0) && (rsp.first_coin == '0), "unreachable result not zero")
	// a nonzero count always comes with a first coin, and a zero count with none
	`MCC_ASSERT_NOW(a_count_coin, rsp.valid && rsp.reachable,
		(rsp.min_coins == '0) == (rsp.first_coin == '0), "count and first coin disagree")

endmodule

`default_nettype wire

// ----- hw/rtl/mcc_ram.sv -----
// Generic simple dual-port RAM with one write port and a registered read port.
`default_nettype none

module mcc_ram #(
	parameter int W     = 8,
	parameter int DEPTH = 2
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [W-1:0]             wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [W-1:0]             rdata
);

	logic [W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

// ----- hw/rtl/mcc_coin_regs.sv -----
// Coin value registers written through the configuration channel.
`default_nettype none

module mcc_coin_regs (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       we,
	input  wire logic [mcc_pkg::IDX_W-1:0]  index,
	input  wire logic [mcc_pkg::COIN_W-1:0] data,
	output      logic [mcc_pkg::COIN_W-1:0] coins [mcc_pkg::NUM_COIN_REGS]
);

	logic [mcc_pkg::COIN_W-1:0] coin_q [mcc_pkg::NUM_COIN_REGS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coin_q[0] <= mcc_pkg::COIN_A_RST;
			coin_q[1] <= mcc_pkg::COIN_B_RST;
			coin_q[2] <= mcc_pkg::COIN_C_RST;
			coin_q[3] <= mcc_pkg::COIN_D_RST;
		end else if (we) begin
			// drop writes beyond the last register
			unique case (index)
				mcc_pkg::REG_COIN_A: coin_q[0] <= data;
				mcc_pkg::REG_COIN_B: coin_q[1] <= data;
				mcc_pkg::REG_COIN_C: coin_q[2] <= data;
				mcc_pkg::REG_COIN_D: coin_q[3] <= data;
				default: ;
			endcase
		end
	end

	assign coins = coin_q;

endmodule

`default_nettype wire

// ----- hw/rtl/mcc_seq.sv -----
// Sequencer: walks sums and coin slots, issues table reads, controls the result load.
`default_nettype none

module mcc_seq #(
	parameter int MAX_AMOUNT = mcc_pkg::MAX_AMOUNT_DEF,
	parameter int NUM_COINS  = mcc_pkg::NUM_COINS_DEF
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 req_valid,
	input  wire logic [mcc_pkg::AMT_W-1:0]            req_amount,
	output      logic                                 req_ready,
	input  wire logic [mcc_pkg::COIN_W-1:0]           coins [mcc_pkg::NUM_COIN_REGS],
	input  wire logic                                 rsp_free,
	output      logic                                 rsp_load,
	output      logic                                 rsp_over,
	output      mcc_pkg::issue_t                      iss,
	output      logic [$clog2(MAX_AMOUNT+1)-1:0]      iss_sum,
	output      logic [mcc_pkg::COIN_W-1:0]           iss_coin,
	output      logic                                 init_we,
	output      logic                                 rd_en,
	output      logic [$clog2(MAX_AMOUNT+1)-1:0]      rd_addr
);

	localparam int AW     = $clog2(MAX_AMOUNT + 1);
	localparam int SW     = (AW > mcc_pkg::COIN_W) ? AW : mcc_pkg::COIN_W;
	localparam int ACTIVE = (NUM_COINS < mcc_pkg::NUM_COIN_REGS) ? NUM_COINS
		: mcc_pkg::NUM_COIN_REGS;
	localparam logic [mcc_pkg::KW-1:0] LAST_K = mcc_pkg::KW'(ACTIVE - 1);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_INIT  = 3'd1;
	localparam logic [2:0] S_FILL  = 3'd2;
	localparam logic [2:0] S_DRAIN = 3'd3;
	localparam logic [2:0] S_READ  = 3'd4;
	localparam logic [2:0] S_RESP  = 3'd5;

	logic [2:0]            st_q;
	logic [AW-1:0]         amt_q;
	logic                  over_q;
	logic [AW-1:0]         sum_q;
	logic [mcc_pkg::KW-1:0] k_q;

	logic [mcc_pkg::COIN_W-1:0] coin;
	logic                       usable;
	logic [SW-1:0]              diff;
	logic                       over_in;

	assign coin    = coins[k_q];
	assign usable  = (coin != '0) && (SW'(coin) <= SW'(sum_q));
	assign diff    = SW'(sum_q) - SW'(coin);
	assign over_in = int'(req_amount) > MAX_AMOUNT;

	always_comb begin
		req_ready  = 1'b0;
		rsp_load   = 1'b0;
		init_we    = 1'b0;
		rd_en      = 1'b0;
		rd_addr    = diff[AW-1:0];
		iss        = '0;
		unique case (st_q)
			S_IDLE:  req_ready = 1'b1;
			S_INIT:  init_we = 1'b1;
			S_FILL: begin
				iss.vld    = 1'b1;
				iss.usable = usable;
				iss.first  = (k_q == '0);
				iss.last   = (k_q == LAST_K);
				rd_en      = usable;
			end
			S_DRAIN: ;
			S_READ: begin
				rd_en   = 1'b1;
				rd_addr = amt_q;
			end
			S_RESP:  rsp_load = rsp_free;
			default: ;
		endcase
	end

	assign rsp_over = over_q;
	assign iss_sum  = sum_q;
	assign iss_coin = coin;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= S_IDLE;
			amt_q  <= '0;
			over_q <= 1'b0;
			sum_q  <= '0;
			k_q    <= '0;
		end else begin
			unique case (st_q)
				S_IDLE: begin
					if (req_valid) begin
						amt_q  <= AW'(req_amount);
						over_q <= over_in;
						st_q   <= over_in ? S_RESP : S_INIT;
					end
				end
				S_INIT: begin
					sum_q <= AW'(1);
					k_q   <= '0;
					st_q  <= (amt_q == '0) ? S_READ : S_FILL;
				end
				S_FILL: begin
					if (k_q == LAST_K) begin
						k_q <= '0;
						if (sum_q == amt_q) begin
							st_q <= S_DRAIN;
						end else begin
							sum_q <= sum_q + AW'(1);
						end
					end else begin
						k_q <= k_q + mcc_pkg::KW'(1);
					end
				end
				S_DRAIN: st_q <= S_READ;
				S_READ:  st_q <= S_RESP;
				S_RESP: begin
					if (rsp_free) begin
						st_q <= S_IDLE;
					end
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end

endmodule

`default_nettype wire

// ----- hw/rtl/mcc_update.sv -----
// Update stage: compares returned counts, keeps the running best and writes each entry.
`default_nettype none

module mcc_update #(
	parameter int MAX_AMOUNT = mcc_pkg::MAX_AMOUNT_DEF
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire mcc_pkg::issue_t                     iss,
	input  wire logic [$clog2(MAX_AMOUNT+1)-1:0]     iss_sum,
	input  wire logic [$clog2(MAX_AMOUNT+1)-1:0]     iss_addr,
	input  wire logic [mcc_pkg::COIN_W-1:0]          iss_coin,
	input  wire logic                                init_we,
	input  wire logic [mcc_pkg::ENTRY_W-1:0]         rd_data,
	output      logic                                we,
	output      logic [$clog2(MAX_AMOUNT+1)-1:0]     waddr,
	output      logic [mcc_pkg::ENTRY_W-1:0]         wdata
);

	localparam int AW = $clog2(MAX_AMOUNT + 1);

	mcc_pkg::issue_t            iss_s1;
	logic [AW-1:0]              sum_s1;
	logic [AW-1:0]              raddr_s1;
	logic [mcc_pkg::COIN_W-1:0] coin_s1;

	logic                       fwd_vld_q;
	logic [AW-1:0]              fwd_addr_q;
	logic [mcc_pkg::CNT_W-1:0]  fwd_cnt_q;
	logic [mcc_pkg::CNT_W-1:0]  best_q;
	logic [mcc_pkg::COIN_W-1:0] first_q;

	logic [mcc_pkg::CNT_W-1:0]  prev;
	logic [mcc_pkg::CNT_W-1:0]  cand;
	logic [mcc_pkg::CNT_W-1:0]  base_best;
	logic [mcc_pkg::COIN_W-1:0] base_first;
	logic                       take;
	logic [mcc_pkg::CNT_W-1:0]  new_best;
	logic [mcc_pkg::COIN_W-1:0] new_first;

	// take the entry written in the read's own cycle from the bypass
	assign prev = (fwd_vld_q && (raddr_s1 == fwd_addr_q)) ? fwd_cnt_q
		: rd_data[mcc_pkg::CNT_W-1:0];
	assign cand       = prev + mcc_pkg::CNT_W'(1);
	assign base_best  = iss_s1.first ? mcc_pkg::NO_WAY : best_q;
	assign base_first = iss_s1.first ? '0 : first_q;
	assign take       = iss_s1.vld && iss_s1.usable && (prev != mcc_pkg::NO_WAY)
		&& (cand < base_best);
	assign new_best   = take ? cand : base_best;
	assign new_first  = take ? coin_s1 : base_first;

	assign we    = init_we || (iss_s1.vld && iss_s1.last);
	assign waddr = init_we ? '0 : sum_s1;
	assign wdata = init_we ? '0 : {new_first, new_best};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			iss_s1    <= '0;
			fwd_vld_q <= 1'b0;
		end else begin
			iss_s1    <= iss;
			fwd_vld_q <= we;
		end
	end

	always_ff @(posedge clk) begin
		sum_s1     <= iss_sum;
		raddr_s1   <= iss_addr;
		coin_s1    <= iss_coin;
		fwd_addr_q <= waddr;
		fwd_cnt_q  <= wdata[mcc_pkg::CNT_W-1:0];
		if (iss_s1.vld) begin
			best_q  <= new_best;
			first_q <= new_first;
		end
	end

endmodule

`default_nettype wire

// ----- test/mcc_change_board_pkg.sv -----
`timescale 1ns / 1ps
// Scoreboard class for the coin change testbench: coin registers, table fill, result check.
package mcc_change_board_pkg;
	import mcc_pkg::*;

	typedef struct packed {
		logic [AMT_W-1:0]  min_coins;
		logic              reachable;
		logic [COIN_W-1:0] first_coin;
	} change_t;

	class change_board;
		logic [COIN_W-1:0] coin_val [NUM_COIN_REGS];
		logic [CNT_W-1:0]  best_count [MAX_AMOUNT_DEF+1];
		logic [COIN_W-1:0] first_pick [MAX_AMOUNT_DEF+1];
		change_t           change_q [$];
		int unsigned       errors;

		function new();
			coin_val[REG_COIN_A[KW-1:0]] = COIN_A_RST;
			coin_val[REG_COIN_B[KW-1:0]] = COIN_B_RST;
			coin_val[REG_COIN_C[KW-1:0]] = COIN_C_RST;
			coin_val[REG_COIN_D[KW-1:0]] = COIN_D_RST;
			errors = 0;
		endfunction

		// Drop writes past the last coin register.
		function void write_coin(logic [IDX_W-1:0] index, logic [COIN_W-1:0] data);
			if (index <= REG_COIN_D)
				coin_val[index[KW-1:0]] = data;
		endfunction

		// Fill the table bottom up; a later coin wins only with strictly fewer coins.
		function change_t fill_table(logic [AMT_W-1:0] amount);
			change_t           res;
			logic [CNT_W-1:0]  best;
			logic [CNT_W-1:0]  prev;
			logic [COIN_W-1:0] pick;
			int                c;
			res = '0;
			best_count[0] = '0;
			first_pick[0] = '0;
			for (int s = 1; s <= int'(amount); s++) begin
				best = NO_WAY;
				pick = '0;
				for (int k = 0; k < NUM_COINS_DEF && k < NUM_COIN_REGS; k++) begin
					c = int'(coin_val[k]);
					if (c == 0 || c > s)
						continue;
					prev = best_count[s - c];
					if (prev == NO_WAY)
						continue;
					if (int'(prev) + 1 < int'(best)) begin
						best = prev + 1'b1;
						pick = coin_val[k];
					end
				end
				best_count[s] = best;
				first_pick[s] = pick;
			end
			if (best_count[amount] != NO_WAY) begin
				res.min_coins  = best_count[amount][AMT_W-1:0];
				res.reachable  = 1'b1;
				res.first_coin = first_pick[amount];
			end
			return res;
		endfunction

		function void note_amount(logic [AMT_W-1:0] amount);
			change_q.push_back(fill_table(amount));
		endfunction

		function void check_result(change_t got);
			change_t want;
			if (change_q.size() == 0) begin
				errors++;
				$display("%0t: unexpected result min_coins %0d reachable %0d first_coin %0d",
					$time, got.min_coins, got.reachable, got.first_coin);
				return;
			end
			want = change_q.pop_front();
			if (got.min_coins !== want.min_coins) begin
				errors++;
				$display("%0t: min_coins expected %0d got %0d",
					$time, want.min_coins, got.min_coins);
			end
			if (got.reachable !== want.reachable) begin
				errors++;
				$display("%0t: reachable expected %0d got %0d",
					$time, want.reachable, got.reachable);
			end
			if (got.first_coin !== want.first_coin) begin
				errors++;
				$display("%0t: first_coin expected %0d got %0d",
					$time, want.first_coin, got.first_coin);
			end
		endfunction

		function int outstanding();
			return change_q.size();
		endfunction
	endclass

endpackage

// ----- test/min_coin_change_top_tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench of the minimum coin change block, driven through its three channels.
module min_coin_change_top_tb;
	import mcc_pkg::*;
	import mcc_change_board_pkg::*;

	localparam int HALF_PERIOD     = 2;
	localparam int RESET_CYCLES    = 8;
	// Covers the slowest item, the largest amount with four coins, with room for stalls.
	localparam int QUIET_LIMIT     = 20000;
	localparam int RANDOM_ROUNDS   = 8;
	localparam int ITEMS_PER_ROUND = 15;
	localparam int HOLD_OFF_CYCLES = 400;
	localparam int SETTLE_CYCLES   = 16;

	typedef enum int {
		PACE_FREE,
		PACE_SENDER_IDLE,
		PACE_RECEIVER_STALL,
		PACE_BOTH
	} pacing_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	int unsigned send_idle_pct = 0;
	int unsigned recv_stall_pct = 0;
	bit          recv_hold = 1'b0;
	int unsigned quiet_cycles = 0;
	change_board board = new();

	mcc_amount_if req_if();
	mcc_result_if rsp_if();
	mcc_cfg_if    cfg_if();

	min_coin_change_top uut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_if),
		.rsp    (rsp_if),
		.cfg    (cfg_if)
	);

	always #(HALF_PERIOD) clk = ~clk;

	// Receiver: decide ready at the falling edge, so it is stable at the rising edge.
	// A long hold-off overrides the random stall.
	initial begin
		rsp_if.ready <= 1'b0;
		forever begin
			@(negedge clk);
			rsp_if.ready <= !recv_hold && ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// Check every result taken at a rising edge against the oldest expectation.
	always @(posedge clk) begin
		if (arst_n && rsp_if.valid && rsp_if.ready)
			board.check_result(change_t'({rsp_if.min_coins, rsp_if.reachable,
				rsp_if.first_coin}));
	end

	// Watchdog: count cycles with no item moving on any channel.
	always @(posedge clk) begin
		if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
				(cfg_if.valid && cfg_if.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("status: fail");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// Offer one amount; idle first at the sender's rate, then hold until taken.
	task automatic send_amount(input logic [AMT_W-1:0] amount);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			req_if.valid <= 1'b0;
			@(negedge clk);
		end
		req_if.valid  <= 1'b1;
		req_if.amount <= amount;
		do @(posedge clk); while (!req_if.ready);
		board.note_amount(amount);
	endtask

	task automatic release_sender();
		@(negedge clk);
		req_if.valid <= 1'b0;
	endtask

	// Advance only once every expected result has been taken.
	task automatic drain();
		while (board.outstanding() != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(input logic [IDX_W-1:0] index, input logic [COIN_W-1:0] data);
		@(negedge clk);
		cfg_if.valid <= 1'b1;
		cfg_if.index <= index;
		cfg_if.data  <= data;
		do @(posedge clk); while (!cfg_if.ready);
		board.write_coin(index, data);
	endtask

	// Load all four coins, then poke an index past the last register, which must be ignored.
	task automatic load_coins(input logic [COIN_W-1:0] coin_a, input logic [COIN_W-1:0] coin_b,
			input logic [COIN_W-1:0] coin_c, input logic [COIN_W-1:0] coin_d);
		logic [IDX_W-1:0] stray;
		stray = REG_COIN_D + IDX_W'($urandom_range(1, 252));
		write_reg(REG_COIN_A, coin_a);
		write_reg(REG_COIN_B, coin_b);
		write_reg(REG_COIN_C, coin_c);
		write_reg(REG_COIN_D, coin_d);
		write_reg(stray, COIN_W'($urandom_range(1023)));
		@(negedge clk);
		cfg_if.valid <= 1'b0;
	endtask

	task automatic set_pacing(input pacing_t mode);
		case (mode)
			PACE_FREE: begin
				send_idle_pct  = 0;
				recv_stall_pct = 0;
			end
			PACE_SENDER_IDLE: begin
				send_idle_pct  = 75;
				recv_stall_pct = 0;
			end
			PACE_RECEIVER_STALL: begin
				send_idle_pct  = 0;
				recv_stall_pct = 75;
			end
			default: begin
				send_idle_pct  = 25;
				recv_stall_pct = 25;
			end
		endcase
	endtask

	// Keep most amounts small: the fill time grows with the amount.
	function automatic logic [AMT_W-1:0] pick_amount();
		int unsigned r;
		r = $urandom_range(99);
		if (r < 70)
			return AMT_W'($urandom_range(63));
		else if (r < 90)
			return AMT_W'($urandom_range(255, 64));
		return AMT_W'($urandom_range(1023));
	endfunction

	// Mostly small coins, with some unused slots and some large values.
	function automatic logic [COIN_W-1:0] pick_coin();
		int unsigned r;
		r = $urandom_range(99);
		if (r < 15)
			return '0;
		else if (r < 25)
			return COIN_W'($urandom_range(1023));
		return COIN_W'($urandom_range(12, 1));
	endfunction

	initial begin
		// Sums under the reset coins 1, 3, 4: small sums, the sum six
		// (three plus three beats four plus one plus one), and wide bit patterns.
		logic [AMT_W-1:0] probe_amounts [13] =
			'{10'd0, 10'd1, 10'd2, 10'd3, 10'd4, 10'd5, 10'd6, 10'd7, 10'd8,
			  10'd1023, 10'd512, 10'd341, 10'd682};

		req_if.valid  <= 1'b0;
		req_if.amount <= '0;
		cfg_if.valid  <= 1'b0;
		cfg_if.index  <= '0;
		cfg_if.data   <= '0;
		repeat (RESET_CYCLES) @(negedge clk);
		arst_n <= 1'b1;

		set_pacing(PACE_FREE);
		foreach (probe_amounts[i])
			send_amount(probe_amounts[i]);
		release_sender();
		drain();

		// Every coin unused: only amount zero is reachable.
		load_coins('0, '0, '0, '0);
		send_amount(10'd0);
		send_amount(10'd5);
		release_sender();
		drain();

		// Largest coin first, seven in the last slot; small sums skip the big coin,
		// six cannot be formed, and 1022 is 146 sevens.
		load_coins(10'd1023, '0, '0, 10'd7);
		send_amount(10'd1023);
		send_amount(10'd14);
		send_amount(10'd6);
		send_amount(10'd1022);
		release_sender();
		drain();

		// Same value in two slots: the earlier slot takes the tie.
		load_coins(10'd5, 10'd5, 10'd2, 10'd1023);
		send_amount(10'd10);
		send_amount(10'd9);
		send_amount(10'd1023);
		release_sender();
		drain();

		// Random coins and amounts, cycling through the pacing modes.
		for (int round = 0; round < RANDOM_ROUNDS; round++) begin
			load_coins(pick_coin(), pick_coin(), pick_coin(), pick_coin());
			set_pacing(pacing_t'(round % 4));
			// Hold the receiver off for a long stretch while the sender keeps
			// offering, so the block backs up and stalls its input.
			if (round == 1) begin
				fork
					begin
						recv_hold = 1'b1;
						repeat (HOLD_OFF_CYCLES) @(posedge clk);
						recv_hold = 1'b0;
					end
				join_none
			end
			repeat (ITEMS_PER_ROUND)
				send_amount(pick_amount());
			// Pause the sender until every result is in before the next setting.
			release_sender();
			drain();
		end

		repeat (SETTLE_CYCLES) @(posedge clk);
		if (board.errors == 0 && board.outstanding() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

// ----- sim.f -----
+incdir+hw/rtl
hw/rtl/mcc_pkg.sv
hw/rtl/mcc_ifs.sv
hw/rtl/mcc_ram.sv
hw/rtl/mcc_coin_regs.sv
hw/rtl/mcc_seq.sv
hw/rtl/mcc_update.sv
hw/rtl/min_coin_change_top.sv
test/mcc_change_board_pkg.sv
test/min_coin_change_top_tb.sv
